### design/overwriting_frame_ring_core_assert.svh
// Assertion macros used by the overwriting frame ring control module.
`ifndef OVERWRITING_FRAME_RING_CORE_ASSERT_SVH
`define OVERWRITING_FRAME_RING_CORE_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define OFR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("overwriting_frame_ring_core: invariant violated");

// Checks that a condition at one edge implies another at the next edge.
`define OFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("overwriting_frame_ring_core: sequence violated");

`endif

### design/ofr_pkg.sv
// Shared types, widths and codes of the overwriting frame ring.
`timescale 1ns / 1ps
package ofr_pkg;

  localparam int unsigned MAX_FRAMES_DEF     = 16;
  localparam int unsigned MAX_SLOT_BYTES_DEF = 4096;
  localparam int unsigned META_BITS_DEF      = 64;

  localparam int unsigned LEN_W     = 13;
  localparam int unsigned META_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CIDX_W    = 4;
  localparam int unsigned OFFS_W    = 12;
  localparam int unsigned HELD_W    = 5;
  localparam int unsigned FIU_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [LEN_W-1:0] POS_LIMIT          = 13'h1FFF;
  localparam logic [LEN_W-1:0] SLOT_BYTES_RST_VAL = 13'd4096;
  localparam logic [FIU_W-1:0] FRAMES_RST_VAL     = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [HELD_W-1:0]   held;
    logic                rd_ok;
    logic                offs_ok;
    logic [OFFS_W-1:0]   offs;
  } ofr_resp_t;

endpackage

### design/ofr_store.sv
// Payload, metadata and size memories of the frame ring.
`timescale 1ns / 1ps
module ofr_store #(
  parameter int unsigned MAX_FRAMES     = ofr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAX_SLOT_BYTES = ofr_pkg::MAX_SLOT_BYTES_DEF,
  parameter int unsigned META_BITS      = ofr_pkg::META_BITS_DEF,
  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int unsigned OFF_W  = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1,
  localparam int unsigned PAY_AW = SLOT_W + OFF_W
) (
  input  logic                        clk_i,
  input  logic                        pay_we_i,
  input  logic [PAY_AW-1:0]           pay_waddr_i,
  input  logic [ofr_pkg::BYTE_W-1:0]  pay_wdata_i,
  input  logic                        slot_we_i,
  input  logic [SLOT_W-1:0]           slot_waddr_i,
  input  logic [META_BITS-1:0]        meta_wdata_i,
  input  logic [ofr_pkg::LEN_W-1:0]   size_wdata_i,
  input  logic                        rd_en_i,
  input  logic [PAY_AW-1:0]           pay_raddr_i,
  input  logic [SLOT_W-1:0]           slot_raddr_i,
  output logic [META_BITS-1:0]        meta_rdata_o,
  output logic [ofr_pkg::LEN_W-1:0]   size_rdata_o,
  output logic [ofr_pkg::BYTE_W-1:0]  byte_rdata_o
);
  import ofr_pkg::*;

  logic [BYTE_W-1:0]    pay_mem  [2**PAY_AW];
  logic [META_BITS-1:0] meta_mem [2**SLOT_W];
  logic [LEN_W-1:0]     size_mem [2**SLOT_W];

  always_ff @(posedge clk_i) begin
    if (pay_we_i) begin
      pay_mem[pay_waddr_i] <= pay_wdata_i;
    end
    if (rd_en_i) begin
      byte_rdata_o <= pay_mem[pay_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we_i) begin
      meta_mem[slot_waddr_i] <= meta_wdata_i;
      size_mem[slot_waddr_i] <= size_wdata_i;
    end
    if (rd_en_i) begin
      meta_rdata_o <= meta_mem[slot_raddr_i];
      size_rdata_o <= size_mem[slot_raddr_i];
    end
  end

endmodule

### design/ofr_ctrl.sv
// Ring bookkeeping, configuration registers and memory addressing.
`timescale 1ns / 1ps
`include "overwriting_frame_ring_core_assert.svh"
module ofr_ctrl #(
  parameter int unsigned MAX_FRAMES     = ofr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAX_SLOT_BYTES = ofr_pkg::MAX_SLOT_BYTES_DEF,
  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int unsigned OFF_W  = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1,
  localparam int unsigned PAY_AW = SLOT_W + OFF_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ofr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ofr_pkg::LEN_W-1:0]     cfg_wdata_i,
  input  logic                          accept_i,
  input  ofr_pkg::op_e                  op_i,
  input  logic [ofr_pkg::LEN_W-1:0]     flen_i,
  input  logic                          complete_i,
  input  logic                          last_i,
  input  logic [ofr_pkg::CIDX_W-1:0]    cidx_i,
  input  logic [ofr_pkg::OFFS_W-1:0]    offs_i,
  output ofr_pkg::ofr_resp_t            resp_o,
  output logic                          pay_we_o,
  output logic [PAY_AW-1:0]             pay_waddr_o,
  output logic                          slot_we_o,
  output logic [SLOT_W-1:0]             slot_waddr_o,
  output logic [ofr_pkg::LEN_W-1:0]     size_wdata_o,
  output logic                          rd_en_o,
  output logic [PAY_AW-1:0]             pay_raddr_o,
  output logic [SLOT_W-1:0]             slot_raddr_o
);
  import ofr_pkg::*;

  localparam int unsigned CMP_W = (SLOT_W + 1 > 6) ? SLOT_W + 1 : 6;
  localparam logic [LEN_W-1:0] SLOT_RST =
    (MAX_SLOT_BYTES < 4096) ? LEN_W'(MAX_SLOT_BYTES) : SLOT_BYTES_RST_VAL;
  localparam logic [FIU_W-1:0] FIU_RST =
    (MAX_FRAMES < 16) ? FIU_W'(MAX_FRAMES) : FRAMES_RST_VAL;

  logic [LEN_W-1:0]  slot_bytes_q, slot_bytes_d;
  logic [FIU_W-1:0]  frames_q, frames_d;
  logic [SLOT_W-1:0] ws_q, ws_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic              rej_q, rej_d;

  logic              cfg_hit;
  logic              is_push;
  logic              rej_now;
  logic              commit;
  logic [CMP_W-1:0]  ws_inc;
  logic [CMP_W-1:0]  rd_sum;
  logic [SLOT_W-1:0] oldest;
  logic              in_range;

  assign cfg_hit = cfg_we_i
                   && (cfg_index_i == CFG_SLOT_BYTES || cfg_index_i == CFG_FRAMES_IN_USE);
  assign is_push = (op_i == OP_PUSH);
  assign rej_now = (pos_q == '0 && !rej_q) ? (!complete_i || flen_i > slot_bytes_q) : rej_q;
  assign commit  = accept_i && is_push && !rej_now && last_i;
  assign ws_inc  = CMP_W'(ws_q) + CMP_W'(1);

  assign in_range = ({1'b0, cidx_i} < held_q);
  assign oldest   = (held_q == frames_q) ? ws_q : '0;

  always_comb begin
    logic [CMP_W-1:0] sum;
    sum = CMP_W'(oldest) + CMP_W'(cidx_i);
    if (sum >= CMP_W'(frames_q)) begin
      sum = sum - CMP_W'(frames_q);
    end
    rd_sum = sum;
  end

  assign pay_we_o     = accept_i && is_push && !rej_now
                        && pos_q < flen_i && pos_q < slot_bytes_q;
  assign pay_waddr_o  = {ws_q, OFF_W'(pos_q)};
  assign slot_we_o    = commit;
  assign slot_waddr_o = ws_q;
  assign size_wdata_o = (flen_i > slot_bytes_q) ? slot_bytes_q : flen_i;
  assign rd_en_o      = accept_i;
  assign slot_raddr_o = SLOT_W'(rd_sum);
  assign pay_raddr_o  = {SLOT_W'(rd_sum), OFF_W'(offs_i)};

  always_comb begin
    slot_bytes_d = slot_bytes_q;
    frames_d     = frames_q;
    ws_d         = ws_q;
    held_d       = held_q;
    pos_d        = pos_q;
    rej_d        = rej_q;
    if (cfg_hit) begin
      if (cfg_index_i == CFG_SLOT_BYTES) begin
        if (cfg_wdata_i == '0) begin
          slot_bytes_d = LEN_W'(1);
        end else if ({4'b0, cfg_wdata_i} > 17'(MAX_SLOT_BYTES)) begin
          slot_bytes_d = LEN_W'(MAX_SLOT_BYTES);
        end else begin
          slot_bytes_d = cfg_wdata_i;
        end
      end else begin
        if (cfg_wdata_i[FIU_W-1:0] == '0) begin
          frames_d = FIU_W'(1);
        end else if ({4'b0, cfg_wdata_i[FIU_W-1:0]} > 9'(MAX_FRAMES)) begin
          frames_d = FIU_W'(MAX_FRAMES);
        end else begin
          frames_d = cfg_wdata_i[FIU_W-1:0];
        end
      end
      ws_d   = '0;
      held_d = '0;
      pos_d  = '0;
      rej_d  = 1'b0;
    end else if (accept_i && is_push) begin
      if (commit) begin
        ws_d = (ws_inc == CMP_W'(frames_q)) ? '0 : SLOT_W'(ws_inc);
        if (held_q < frames_q) begin
          held_d = held_q + HELD_W'(1);
        end
      end
      if (last_i) begin
        pos_d = '0;
        rej_d = 1'b0;
      end else begin
        rej_d = rej_now;
        if (pos_q != POS_LIMIT) begin
          pos_d = pos_q + LEN_W'(1);
        end
      end
    end
  end

  always_comb begin
    resp_o.held    = accept_i && is_push ? held_d : held_q;
    resp_o.offs    = offs_i;
    resp_o.offs_ok = ({5'b0, offs_i} < 17'(MAX_SLOT_BYTES));
    resp_o.rd_ok   = 1'b0;
    resp_o.status  = ST_OK;
    if (is_push) begin
      if (rej_now) begin
        resp_o.status = complete_i ? ST_TOO_LONG : ST_INCOMPLETE;
      end
    end else if (in_range) begin
      resp_o.rd_ok = 1'b1;
    end else begin
      resp_o.status = ST_RANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= SLOT_RST;
      frames_q     <= FIU_RST;
      ws_q         <= '0;
      held_q       <= '0;
      pos_q        <= '0;
      rej_q        <= 1'b0;
    end else begin
      slot_bytes_q <= slot_bytes_d;
      frames_q     <= frames_d;
      ws_q         <= ws_d;
      held_q       <= held_d;
      pos_q        <= pos_d;
      rej_q        <= rej_d;
    end
  end

  `OFR_ASSERT_ALWAYS(held_within_ring, clk_i, rst_ni, held_q <= frames_q)
  `OFR_ASSERT_ALWAYS(write_slot_within_ring, clk_i, rst_ni, CMP_W'(ws_q) < CMP_W'(frames_q))
  `OFR_ASSERT_NEXT(ring_empty_after_cfg, clk_i, rst_ni, cfg_hit, (held_q == '0) && (pos_q == '0) && !rej_q)
  `OFR_ASSERT_NEXT(commit_counts_frame, clk_i, rst_ni, commit && (held_q < frames_q), held_q == $past(held_q) + HELD_W'(1))

endmodule

### design/overwriting_frame_ring_core.sv
// Top level of the overwriting frame ring: stream ports, result stage and memories.
// A result passes the s1 register and the output register before m_axis_tvalid.
// Throughput: one transaction per cycle unless m_axis_tready stalls the output.
// Reset clears the ring (no frames held) and sets slot_bytes to 4096 and frames_in_use to 16.
`timescale 1ns / 1ps
module overwriting_frame_ring_core #(
  parameter int unsigned MAX_FRAMES     = ofr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAX_SLOT_BYTES = ofr_pkg::MAX_SLOT_BYTES_DEF,
  parameter int unsigned META_BITS      = ofr_pkg::META_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ofr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ofr_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // frame_length, metadata_word, frame_complete, data_byte,
  // age_index, byte_offset, zero padding
  input  logic [ofr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frames_held, read_metadata, read_size, read_byte, zero padding
  output logic [ofr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser
);
  import ofr_pkg::*;

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned OFF_W  = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
  localparam int unsigned PAY_AW = SLOT_W + OFF_W;

  logic [LEN_W-1:0]  in_flen;
  logic [META_W-1:0] in_meta;
  logic              in_complete;
  logic [BYTE_W-1:0] in_byte;
  logic [CIDX_W-1:0] in_cidx;
  logic [OFFS_W-1:0] in_offs;
  op_e               in_op;

  logic              accept;
  logic              s1_adv;
  logic              s1_valid_q, s1_valid_d;
  ofr_resp_t         s1_q;
  ofr_resp_t         resp;
  logic              out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  status_e           out_status_q;

  logic              pay_we;
  logic [PAY_AW-1:0] pay_waddr;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [LEN_W-1:0]  size_wdata;
  logic              rd_en;
  logic [PAY_AW-1:0] pay_raddr;
  logic [SLOT_W-1:0] slot_raddr;
  logic [META_BITS-1:0] meta_rdata;
  logic [LEN_W-1:0]  size_rdata;
  logic [BYTE_W-1:0] byte_rdata;

  assign in_flen     = s_axis_tdata[12:0];
  assign in_meta     = s_axis_tdata[76:13];
  assign in_complete = s_axis_tdata[77];
  assign in_byte     = s_axis_tdata[85:78];
  assign in_cidx     = s_axis_tdata[89:86];
  assign in_offs     = s_axis_tdata[101:90];
  assign in_op       = op_e'(s_axis_tuser[0]);

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ofr_ctrl #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .op_i         (in_op),
    .flen_i       (in_flen),
    .complete_i   (in_complete),
    .last_i       (s_axis_tlast),
    .cidx_i       (in_cidx),
    .offs_i       (in_offs),
    .resp_o       (resp),
    .pay_we_o     (pay_we),
    .pay_waddr_o  (pay_waddr),
    .slot_we_o    (slot_we),
    .slot_waddr_o (slot_waddr),
    .size_wdata_o (size_wdata),
    .rd_en_o      (rd_en),
    .pay_raddr_o  (pay_raddr),
    .slot_raddr_o (slot_raddr)
  );

  ofr_store #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_SLOT_BYTES (MAX_SLOT_BYTES),
    .META_BITS      (META_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .pay_we_i     (pay_we),
    .pay_waddr_i  (pay_waddr),
    .pay_wdata_i  (in_byte),
    .slot_we_i    (slot_we),
    .slot_waddr_i (slot_waddr),
    .meta_wdata_i (META_BITS'(in_meta)),
    .size_wdata_i (size_wdata),
    .rd_en_i      (rd_en),
    .pay_raddr_i  (pay_raddr),
    .slot_raddr_i (slot_raddr),
    .meta_rdata_o (meta_rdata),
    .size_rdata_o (size_rdata),
    .byte_rdata_o (byte_rdata)
  );

  always_comb begin
    logic [META_W-1:0] r_meta;
    logic [LEN_W-1:0]  r_size;
    logic [BYTE_W-1:0] r_byte;
    r_meta = '0;
    r_size = '0;
    r_byte = '0;
    if (s1_q.rd_ok) begin
      r_meta = META_W'(meta_rdata);
      r_size = size_rdata;
      if (s1_q.offs_ok && {1'b0, s1_q.offs} < size_rdata) begin
        r_byte = byte_rdata;
      end
    end
    out_data_d = {6'b0, r_byte, r_size, r_meta, s1_q.held};
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= resp;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q   <= out_data_d;
      out_status_q <= s1_q.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule
